@@ design/ssf_pkg.sv @@
package ssf_pkg;

  // array geometry and storage
  localparam int LANES       = 2;
  localparam int MEM_DEPTH   = 256;
  localparam int DATA_BITS   = 16;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int WAVE_W      = 5;

  // field widths fixed by the interface
  localparam int INDEX_W    = 8;
  localparam int VALUE_W    = 16;
  localparam int OUT_LANE_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_START = 1'b1;

  // feed side codes
  localparam logic FEED_SIDE = 1'b0;
  localparam logic FEED_TOP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_GAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_B_GAP  = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic mem_write;
    logic clear;
    logic issue;
  } ssf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic no_waves;
    logic final_pos;
    logic stage_free;
    logic pipe_empty;
  } ssf_stat_t;

endpackage

@@ design/ssf_ram.sv @@
module ssf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/ssf_ctrl.sv @@
module ssf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  input  ssf_pkg::ssf_stat_t stat,
  output ssf_pkg::ssf_cmd_t  cmd
);
  import ssf_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // commands
  always_comb begin
    cmd           = '0;
    cmd.mem_write = accept && (in_operation == OP_WRITE);
    cmd.clear     = accept && (in_operation == OP_START);
    cmd.issue     = (state_r == S_RUN) && stat.stage_free;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_operation == OP_START) && !stat.no_waves) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.issue && stat.final_pos) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.pipe_empty) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // nothing is in flight while new beats are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> stat.pipe_empty)
    else $error("input taken while results in flight");

  // a start with waves to send closes the input
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clear && !stat.no_waves) |=> !in_ready)
    else $error("input still open after start");

endmodule

@@ design/ssf_dp.sv @@
module ssf_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ssf_pkg::ssf_cmd_t                cmd,
  output ssf_pkg::ssf_stat_t               stat,
  input  logic [ssf_pkg::INDEX_W-1:0]      in_word_index,
  input  logic signed [ssf_pkg::VALUE_W-1:0] in_word_value,
  input  logic                             cfg_we,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_feed_side,
  output logic [ssf_pkg::OUT_LANE_W-1:0]   out_lane,
  output logic [ssf_pkg::WAVE_W-1:0]       out_wave,
  output logic signed [ssf_pkg::VALUE_W-1:0] out_feed_value,
  output logic                             out_last
);
  import ssf_pkg::*;

  // configuration registers
  logic [7:0] a_base_r, b_base_r;
  logic [3:0] a_cols_r, a_gap_r, b_rows_r, b_cols_r, b_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_base_r <= '0;
      a_cols_r <= 4'd1;
      a_gap_r  <= '0;
      b_base_r <= '0;
      b_rows_r <= 4'd1;
      b_cols_r <= 4'd1;
      b_gap_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_A_BASE: a_base_r <= cfg_data;
        REG_A_COLS: a_cols_r <= cfg_data[3:0];
        REG_A_GAP:  a_gap_r  <= cfg_data[3:0];
        REG_B_BASE: b_base_r <= cfg_data;
        REG_B_ROWS: b_rows_r <= cfg_data[3:0];
        REG_B_COLS: b_cols_r <= cfg_data[3:0];
        REG_B_GAP:  b_gap_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // wave count is the longer stream plus the lane skew
  logic [3:0]        span;
  logic [WAVE_W-1:0] waves;
  assign span  = (a_cols_r > b_rows_r) ? a_cols_r : b_rows_r;
  assign waves = WAVE_W'(32'(span) + LANES - 1);

  // position counters
  logic [WAVE_W-1:0] wave_r, wave_nxt;
  logic              side_r, side_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              lane_end, end_pos;

  assign lane_end = (lane_r == LANE_W'(LANES - 1));
  assign end_pos  = (wave_r == waves - WAVE_W'(1)) && (side_r == FEED_TOP) && lane_end;

  always_comb begin
    wave_nxt = wave_r;
    side_nxt = side_r;
    lane_nxt = lane_r;
    cnt_nxt  = cnt_r;
    if (cmd.clear) begin
      wave_nxt = '0;
      side_nxt = FEED_SIDE;
      lane_nxt = '0;
      cnt_nxt  = '0;
    end else if (cmd.issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (lane_end) begin
        lane_nxt = '0;
        side_nxt = ~side_r;
        if (side_r == FEED_TOP) begin
          wave_nxt = wave_r + WAVE_W'(1);
        end
      end else begin
        lane_nxt = lane_r + LANE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= '0;
      side_r <= FEED_SIDE;
      lane_r <= '0;
      cnt_r  <= '0;
    end else begin
      wave_r <= wave_nxt;
      side_r <= side_nxt;
      lane_r <= lane_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // lane windows
  logic [5:0]        w_ext, l_ext;
  logic [WAVE_W-1:0] d;
  logic              a_win, b_win, in_win;
  assign w_ext  = 6'(wave_r);
  assign l_ext  = 6'(lane_r);
  assign d      = wave_r - WAVE_W'(lane_r);
  assign a_win  = (w_ext >= l_ext) && (w_ext < l_ext + 6'(a_cols_r));
  assign b_win  = (w_ext >= l_ext) && (w_ext < l_ext + 6'(b_rows_r));
  assign in_win = (side_r == FEED_TOP) ? b_win : a_win;

  // addresses, wrapped to the memory depth
  logic [4:0]  a_pitch, b_pitch;
  logic [3:0]  a_rev, b_rev;
  logic [7:0]  side_off;
  logic [8:0]  top_off;
  logic [15:0] side_sum, top_sum;
  logic [ADDR_W-1:0] raddr;

  assign a_pitch  = 5'(a_cols_r) + 5'(a_gap_r);
  assign b_pitch  = 5'(b_cols_r) + 5'(b_gap_r);
  assign a_rev    = a_cols_r - 4'(d) - 4'd1;
  assign b_rev    = b_rows_r - 4'(d) - 4'd1;
  assign side_off = 8'(lane_r) * 8'(a_pitch);
  assign top_off  = 9'(b_rev) * 9'(b_pitch);
  assign side_sum = 16'(a_base_r) + 16'(side_off) + 16'(a_rev);
  assign top_sum  = 16'(b_base_r) + 16'(top_off) + 16'(lane_r);
  assign raddr    = (side_r == FEED_TOP) ? top_sum[ADDR_W-1:0] : side_sum[ADDR_W-1:0];

  // matrix store
  logic signed [31:0]    wr_ext;
  logic [31:0]           wr_idx;
  logic [DATA_BITS-1:0]  rdata;
  logic signed [31:0]    rd_ext;
  assign wr_ext = 32'(in_word_value);
  assign wr_idx = 32'(in_word_index);

  ssf_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.mem_write),
    .waddr (wr_idx[ADDR_W-1:0]),
    .wdata (wr_ext[DATA_BITS-1:0]),
    .re    (cmd.issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ext = 32'(signed'(rdata));

  // read stage and output register
  logic              v1_r;
  logic              s1_side_r, s1_win_r, s1_last_r;
  logic [LANE_W-1:0] s1_lane_r;
  logic [WAVE_W-1:0] s1_wave_r;
  logic              out_valid_r;
  logic              out_side_r, out_last_r;
  logic [OUT_LANE_W-1:0] out_lane_r;
  logic [WAVE_W-1:0] out_wave_r;
  logic [VALUE_W-1:0] out_value_r;
  logic              out_free, stage_free;

  assign out_free   = !out_valid_r || out_ready;
  assign stage_free = !v1_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (stage_free) begin
        v1_r <= cmd.issue;
      end
      if (out_free) begin
        out_valid_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free) begin
      s1_side_r <= side_r;
      s1_lane_r <= lane_r;
      s1_wave_r <= wave_r;
      s1_win_r  <= in_win;
      s1_last_r <= end_pos || (cnt_r == CNT_W'(MAX_RESULTS - 1));
    end
    if (out_free) begin
      out_side_r  <= s1_side_r;
      out_lane_r  <= OUT_LANE_W'(s1_lane_r);
      out_wave_r  <= s1_wave_r;
      out_value_r <= s1_win_r ? rd_ext[VALUE_W-1:0] : '0;
      out_last_r  <= s1_last_r;
    end
  end

  // status
  always_comb begin
    stat            = '0;
    stat.no_waves   = (waves == '0);
    stat.final_pos  = end_pos || (cnt_r == CNT_W'(MAX_RESULTS - 1));
    stat.stage_free = stage_free;
    stat.pipe_empty = !v1_r && !out_valid_r;
  end

  assign out_valid      = out_valid_r;
  assign out_feed_side  = out_side_r;
  assign out_lane       = out_lane_r;
  assign out_wave       = out_wave_r;
  assign out_feed_value = signed'(out_value_r);
  assign out_last       = out_last_r;

  // a read is launched only into a free stage
  a_issue_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> stage_free)
    else $error("read issued into a stalled stage");

  // nothing follows the final beat of a stream
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && out_last_r) |=> !out_valid_r)
    else $error("beat after final result");

  // lane counter stays within the array
  a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
    lane_r <= LANE_W'(LANES - 1))
    else $error("lane counter out of range");

endmodule

@@ design/systolic_skew_feeder.sv @@
// channel | ports                                           | direction
// in      | in_valid/in_ready, in_operation, in_word_index,  | into block
//         | in_word_value                                    |
// out     | out_valid/out_ready, out_feed_side, out_lane,    | out of block
//         | out_wave, out_feed_value, out_last               |
// cfg     | cfg_we, cfg_index, cfg_data                      | into block
//
// a write beat lands in the matrix store as soon as it is accepted
// a start beat yields min(64, 2*LANES*waves) results, one per cycle while out_ready
//   is high; each passes the address and store read stage, then the output register
// in_ready stays low from a start beat with waves until after its final result is taken
// reset is synchronous, active low, and leaves the store contents unknown
// out_ready low holds a waiting result, freezing the sequencer and a full read stage
module systolic_skew_feeder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic [ssf_pkg::INDEX_W-1:0]        in_word_index,
  input  logic signed [ssf_pkg::VALUE_W-1:0] in_word_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_feed_side,
  output logic [ssf_pkg::OUT_LANE_W-1:0]     out_lane,
  output logic [ssf_pkg::WAVE_W-1:0]         out_wave,
  output logic signed [ssf_pkg::VALUE_W-1:0] out_feed_value,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssf_pkg::*;

  ssf_cmd_t  cmd;
  ssf_stat_t stat;

  // sequencer
  ssf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // store, address generation and output stage
  ssf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_word_index  (in_word_index),
    .in_word_value  (in_word_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_feed_side  (out_feed_side),
    .out_lane       (out_lane),
    .out_wave       (out_wave),
    .out_feed_value (out_feed_value),
    .out_last       (out_last)
  );

endmodule
